/* hw/rtl/line_rasterizer_core_defines.svh */
// assertion macros shared by the rasterizer rtl
`ifndef LINE_RASTERIZER_CORE_DEFINES_SVH
`define LINE_RASTERIZER_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LRC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("line rasterizer check failed");

// next-cycle implication, checked outside reset
`define LRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("line rasterizer check failed");

`endif

/* hw/rtl/lrc_pkg.sv */
// shared types and constants for the line rasterizer
`default_nettype none

package lrc_pkg;

  localparam int COORD_BITS = 12;
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 3;

  // both internal queues are two deep
  localparam int QDEPTH    = 2;
  localparam int QPTR_BITS = 1;
  localparam int QCNT_BITS = 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] ucoord_t;
  typedef logic signed [DELTA_BITS-1:0] delta_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;
  typedef logic        [QPTR_BITS-1:0]  qptr_t;
  typedef logic        [QCNT_BITS-1:0]  qcnt_t;

  // classified item handed from front to back
  typedef struct packed {
    logic    is_tick;
    logic    high_slope;
    logic    minor_neg;
    coord_t  start_x;
    coord_t  start_y;
    ucoord_t major_delta;
    err_t    err_init;
    err_t    err_inc_pos;
    err_t    err_inc_neg;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } opq_t;

  typedef struct packed {
    logic    pixel_valid;
    coord_t  pixel_x;
    coord_t  pixel_y;
    ucoord_t offset;
    ucoord_t span;
    logic    last;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/lrc_front.sv */
// front end: line setup for loads and the op queue toward the walker
`default_nettype none

module lrc_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 push,
  output logic                full,
  input  wire                 in_command,
  input  lrc_pkg::coord_t     in_start_x,
  input  lrc_pkg::coord_t     in_start_y,
  input  lrc_pkg::coord_t     in_end_x,
  input  lrc_pkg::coord_t     in_end_y,
  output lrc_pkg::opq_t       opq,
  input  wire                 op_pop
);

  lrc_pkg::delta_t  dx, dy, dx_abs, dy_abs, dmaj, dmin;
  lrc_pkg::ucoord_t adx, ady, maj_d, min_d;
  logic             high, swap, dmin_pos;
  lrc_pkg::err_t    two_min, two_maj;
  lrc_pkg::op_t     new_op;

  lrc_pkg::op_t     mem_r [lrc_pkg::QDEPTH];
  lrc_pkg::qptr_t   wr_ptr_r, rd_ptr_r;
  lrc_pkg::qcnt_t   cnt_r, cnt_nxt;
  logic             wr, rd;

  // setup: deltas, major axis pick, endpoint order, error seed
  always_comb begin
    dx     = lrc_pkg::delta_t'(in_end_x) - lrc_pkg::delta_t'(in_start_x);
    dy     = lrc_pkg::delta_t'(in_end_y) - lrc_pkg::delta_t'(in_start_y);
    dx_abs = dx[lrc_pkg::DELTA_BITS-1] ? -dx : dx;
    dy_abs = dy[lrc_pkg::DELTA_BITS-1] ? -dy : dy;
    adx    = dx_abs[lrc_pkg::COORD_BITS-1:0];
    ady    = dy_abs[lrc_pkg::COORD_BITS-1:0];
    high   = !(ady < adx);
    dmaj   = high ? dy : dx;
    dmin   = high ? dx : dy;
    swap   = dmaj[lrc_pkg::DELTA_BITS-1];
    maj_d  = high ? ady : adx;
    min_d  = high ? adx : ady;
    dmin_pos = !dmin[lrc_pkg::DELTA_BITS-1] && (dmin != '0);
    two_min  = $signed({2'b00, min_d, 1'b0});
    two_maj  = $signed({2'b00, maj_d, 1'b0});

    new_op.is_tick     = (in_command == lrc_pkg::CMD_TICK);
    new_op.high_slope  = high;
    new_op.minor_neg   = swap ? dmin_pos : dmin[lrc_pkg::DELTA_BITS-1];
    new_op.start_x     = swap ? in_end_x : in_start_x;
    new_op.start_y     = swap ? in_end_y : in_start_y;
    new_op.major_delta = maj_d;
    new_op.err_init    = two_min - $signed({3'b000, maj_d});
    new_op.err_inc_pos = two_min - two_maj;
    new_op.err_inc_neg = two_min;
  end

  assign full      = (cnt_r == lrc_pkg::qcnt_t'(lrc_pkg::QDEPTH));
  assign wr        = push && !full;
  assign rd        = op_pop && (cnt_r != '0);
  assign opq.valid = (cnt_r != '0);
  assign opq.op    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr && !rd) begin
      cnt_nxt = cnt_r + lrc_pkg::qcnt_t'(1);
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - lrc_pkg::qcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (wr) wr_ptr_r <= wr_ptr_r + lrc_pkg::qptr_t'(1);
      if (rd) rd_ptr_r <= rd_ptr_r + lrc_pkg::qptr_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wr_ptr_r] <= new_op;
  end

endmodule

`default_nettype wire

/* hw/rtl/lrc_back.sv */
// back end: bresenham walker and result queue
`default_nettype none

module lrc_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  lrc_pkg::opq_t       opq,
  output logic                op_pop,
  output logic                empty,
  input  wire                 pop,
  output logic                out_pixel_valid,
  output lrc_pkg::coord_t     out_pixel_x,
  output lrc_pkg::coord_t     out_pixel_y,
  output lrc_pkg::ucoord_t    out_offset,
  output lrc_pkg::ucoord_t    out_span,
  output logic                out_last
);

  // walker state
  logic             active_r, high_r, neg_r;
  lrc_pkg::coord_t  cur_x_r, cur_y_r;
  lrc_pkg::ucoord_t major_r, step_r;
  lrc_pkg::err_t    err_r, inc_pos_r, inc_neg_r;

  logic             err_gt0, is_last, take, res_push, res_full, res_pop;
  lrc_pkg::coord_t  minor_cur, minor_step;
  lrc_pkg::result_t res;

  lrc_pkg::result_t mem_r [lrc_pkg::QDEPTH];
  lrc_pkg::qptr_t   wr_ptr_r, rd_ptr_r;
  lrc_pkg::qcnt_t   cnt_r, cnt_nxt;
  lrc_pkg::result_t head;

  assign res_full = (cnt_r == lrc_pkg::qcnt_t'(lrc_pkg::QDEPTH));
  assign empty    = (cnt_r == '0);
  assign res_pop  = pop && !empty;

  // a load never waits on the result side
  assign take     = opq.valid && (!opq.op.is_tick || !res_full);
  assign op_pop   = take;
  assign res_push = take && opq.op.is_tick;

  assign err_gt0    = !err_r[lrc_pkg::ERR_BITS-1] && (err_r != '0);
  assign is_last    = (step_r == major_r);
  assign minor_cur  = high_r ? cur_x_r : cur_y_r;
  assign minor_step = neg_r ? minor_cur - lrc_pkg::coord_t'(1)
                            : minor_cur + lrc_pkg::coord_t'(1);

  always_comb begin
    res = '0;
    if (active_r) begin
      res.pixel_valid = 1'b1;
      res.pixel_x     = cur_x_r;
      res.pixel_y     = cur_y_r;
      res.offset      = step_r;
      res.span        = major_r;
      res.last        = is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (take) begin
      if (!opq.op.is_tick) begin
        active_r <= 1'b1;
      end else if (active_r && is_last) begin
        active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !opq.op.is_tick) begin
      high_r    <= opq.op.high_slope;
      neg_r     <= opq.op.minor_neg;
      cur_x_r   <= opq.op.start_x;
      cur_y_r   <= opq.op.start_y;
      major_r   <= opq.op.major_delta;
      step_r    <= '0;
      err_r     <= opq.op.err_init;
      inc_pos_r <= opq.op.err_inc_pos;
      inc_neg_r <= opq.op.err_inc_neg;
    end else if (take && active_r) begin
      if (high_r) begin
        cur_y_r <= cur_y_r + lrc_pkg::coord_t'(1);
        if (err_gt0) cur_x_r <= minor_step;
      end else begin
        cur_x_r <= cur_x_r + lrc_pkg::coord_t'(1);
        if (err_gt0) cur_y_r <= minor_step;
      end
      err_r  <= err_r + (err_gt0 ? inc_pos_r : inc_neg_r);
      step_r <= step_r + lrc_pkg::ucoord_t'(1);
    end
  end

  // result queue
  always_comb begin
    cnt_nxt = cnt_r;
    if (res_push && !res_pop) begin
      cnt_nxt = cnt_r + lrc_pkg::qcnt_t'(1);
    end else if (res_pop && !res_push) begin
      cnt_nxt = cnt_r - lrc_pkg::qcnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (res_push) wr_ptr_r <= wr_ptr_r + lrc_pkg::qptr_t'(1);
      if (res_pop)  rd_ptr_r <= rd_ptr_r + lrc_pkg::qptr_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) mem_r[wr_ptr_r] <= res;
  end

  assign head            = mem_r[rd_ptr_r];
  assign out_pixel_valid = head.pixel_valid;
  assign out_pixel_x     = head.pixel_x;
  assign out_pixel_y     = head.pixel_y;
  assign out_offset      = head.offset;
  assign out_span        = head.span;
  assign out_last        = head.last;

endmodule

`default_nettype wire

/* hw/rtl/line_rasterizer_core.sv */
// top level of the bresenham line rasterizer
`default_nettype none
`include "line_rasterizer_core_defines.svh"

// Bresenham line walker with queue-style ports on both sides. A load
// (command 0) carries two signed endpoints and produces no result; it
// replaces any line in progress. Each tick (command 1) produces exactly one
// result: the next pixel with its major-axis offset, the span and a last
// mark, or pixel_valid 0 with all fields zero when no line is active.
// Sustained rate while neither side stalls is one item per clock in and one
// result per clock out; the walker step is a single error-term add and
// compare per clock. A pushed item goes into the op queue, the walker takes
// it from there and puts a tick's result into the result queue, whose head
// drives the out_ ports. A two-deep op queue sits between the setup front
// end and the walker, and a two-deep result queue sits at the output, so
// either side can stall on its own without a bubble. No clearing pass after
// reset: the block takes items in the first cycle rst_n is high.

module line_rasterizer_core (
  input  wire                 clk,
  input  wire                 rst_n,
  // input channel
  input  wire                 push,
  output logic                full,
  input  wire                 in_command,
  input  lrc_pkg::coord_t     in_start_x,
  input  lrc_pkg::coord_t     in_start_y,
  input  lrc_pkg::coord_t     in_end_x,
  input  lrc_pkg::coord_t     in_end_y,
  // result channel
  output logic                empty,
  input  wire                 pop,
  output logic                out_pixel_valid,
  output lrc_pkg::coord_t     out_pixel_x,
  output lrc_pkg::coord_t     out_pixel_y,
  output lrc_pkg::ucoord_t    out_offset,
  output lrc_pkg::ucoord_t    out_span,
  output logic                out_last
);

  // classified ops from setup to walker, and the walker's pop back
  lrc_pkg::opq_t opq;
  logic          op_pop;

  // front end does the load setup: deltas, axis pick, endpoint swap and
  // error seed, so the walker only ever does one error-term add per step
  lrc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_command (in_command),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .opq        (opq),
    .op_pop     (op_pop)
  );

  // back end holds the line state and the result queue; a tick is taken
  // only when the result queue has room, a load always
  lrc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .opq             (opq),
    .op_pop          (op_pop),
    .empty           (empty),
    .pop             (pop),
    .out_pixel_valid (out_pixel_valid),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_offset      (out_offset),
    .out_span        (out_span),
    .out_last        (out_last)
  );

  // no op waiting means no result can show up
  `LRC_ASSERT_NEXT(a_no_op_no_result, empty && !opq.valid, empty)
  // a load transfer never creates a result
  `LRC_ASSERT_NEXT(a_load_no_result, empty && opq.valid && !opq.op.is_tick, empty)
  // every tick the walker takes lands in the result queue
  `LRC_ASSERT_NEXT(a_tick_gives_result, op_pop && opq.op.is_tick, !empty)
  // the walker only pops what the op queue holds
  `LRC_ASSERT_NOW(a_pop_needs_op, op_pop, opq.valid)

endmodule

`default_nettype wire
